FILE: hw/rtl/gdsc_pkg.sv
// ----------------------------------------------------------------------------
// gdsc_pkg: shared types and constants of the dictionary symbol coder
// Beat layouts, codebook entry layout, sequencer states and the prefix mask.
// ----------------------------------------------------------------------------
package gdsc_pkg;

    // Codebook depth and the width of an entry number.
    localparam int BOOK_ENTRIES = 256;
    localparam int IDX_W        = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;
    localparam int SYM_BYTES    = 4;

    // Item kinds carried by an input beat.
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_END    = 2'd2,
        MODE_DECODE = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode        mode;
        logic [7:0]   entry_index;
        logic [2:0]   entry_length;
        logic [31:0]  entry_bytes;
        logic [7:0]   value;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]   out_byte;
        logic         last_of_run;
    } t_out_beat;

    // One codebook entry as it is kept in the RAM.
    typedef struct packed {
        logic [2:0]   len;
        logic [31:0]  sym;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_FIN   = 6'b000100,
        ST_EMIT  = 6'b001000,
        ST_DRD   = 6'b010000,
        ST_DEMIT = 6'b100000
    } t_state;

    // Mask that keeps the first n symbol bytes of a word.
    function automatic logic [31:0] prefix_mask(input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/greedy_dictionary_symbol_coder_unit.sv
// ----------------------------------------------------------------------------
// greedy_dictionary_symbol_coder_unit: greedy longest-match dictionary coder
// Codebook load, window encode with longest match, end flush and decode.
// ----------------------------------------------------------------------------
// Load items, and encode items that do not fill the four-byte window, are
// taken in the idle state. Each code that the block emits costs one full pass
// over the codebook, one entry per cycle through the single read port of the
// codebook RAM, then a finish state for the last compare and an emit state
// that sends the code once the output is free. An encode item that fills the
// window runs one such pass, an end item runs one for each code it emits (up
// to three), and a decode item reads its entry and then sends one beat per
// symbol byte. The input is not ready while an item is at work; one result
// beat can wait in the output register while the next item is accepted.
module greedy_dictionary_symbol_coder_unit
    import gdsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BOOK_ENTRIES - 1);

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_addr, n_addr;
    logic                     r_cmp_vld;
    logic [IDX_W-1:0]         r_cmp_idx;
    logic                     r_ent_vld;
    logic [BOOK_ENTRIES-1:0]  r_vld_bits;
    logic [31:0]              r_window, n_window;
    logic [2:0]               r_fill, n_fill;
    logic [2:0]               r_avail, n_avail;
    logic                     r_is_end, n_is_end;
    logic [3:0]               r_hit_vld;
    logic [IDX_W-1:0]         r_hit_idx [SYM_BYTES];
    logic                     n_hit_clr;
    logic [31:0]              r_dec_sym, n_dec_sym;
    logic [2:0]               r_dec_len, n_dec_len;
    logic [1:0]               r_k, n_k;
    logic                     r_ovld, n_ovld;
    t_out_beat                r_odata, n_odata;

    logic                     in_acc;
    logic                     out_free;
    logic                     load_ok;
    logic                     dec_ok;
    logic [2:0]               load_len;
    logic [IDX_W-1:0]         rd_addr;
    logic [ENTRY_W-1:0]       ram_q;
    t_entry                   ram_entry;
    t_entry                   wr_entry;
    logic [3:0]               hit;
    logic [IDX_W-1:0]         pick_code;
    logic [2:0]               pick_used;
    logic [2:0]               left_fill;
    logic [31:0]              push_window;
    logic [2:0]               dec_len;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_ovld || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign load_ok    = ({1'b0, i_in_data.entry_index} < 9'(BOOK_ENTRIES));
    assign dec_ok     = ({1'b0, i_in_data.value} < 9'(BOOK_ENTRIES));
    assign load_len   = (i_in_data.entry_length > 3'(SYM_BYTES)) ? 3'(SYM_BYTES)
                                                                 : i_in_data.entry_length;

    // Codebook storage: the idle state reads the decode address directly.
    assign rd_addr      = (r_state == ST_IDLE) ? i_in_data.value[IDX_W-1:0] : r_addr;
    assign wr_entry.len = load_len;
    assign wr_entry.sym = i_in_data.entry_bytes & prefix_mask(load_len);

    gdsc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BOOK_ENTRIES)
    ) u_book (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && (i_in_data.mode == MODE_LOAD) && load_ok),
        .i_wr_addr (i_in_data.entry_index[IDX_W-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    assign ram_entry = t_entry'(ram_q);

    // Shared compare unit, fed one entry per cycle during a pass.
    gdsc_match u_match (
        .i_entry     (ram_entry),
        .i_entry_vld (r_ent_vld && r_cmp_vld),
        .i_window    (r_window),
        .i_avail     (r_avail),
        .o_hit       (hit)
    );

    // Pick the longest match; a hit on entry zero only counts for one byte.
    always_comb begin
        pick_code = '0;
        pick_used = 3'd1;
        if (r_hit_vld[3] && (r_hit_idx[3] != '0)) begin
            pick_code = r_hit_idx[3];
            pick_used = 3'd4;
        end else if (r_hit_vld[2] && (r_hit_idx[2] != '0)) begin
            pick_code = r_hit_idx[2];
            pick_used = 3'd3;
        end else if (r_hit_vld[1] && (r_hit_idx[1] != '0)) begin
            pick_code = r_hit_idx[1];
            pick_used = 3'd2;
        end else if (r_hit_vld[0]) begin
            pick_code = r_hit_idx[0];
        end
    end

    assign left_fill   = r_fill - pick_used;
    assign push_window = (r_window & prefix_mask(r_fill))
                       | (32'(i_in_data.value) << {r_fill[1:0], 3'b000});
    assign dec_len     = r_ent_vld ? ram_entry.len : 3'd0;

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_window  = r_window;
        n_fill    = r_fill;
        n_avail   = r_avail;
        n_is_end  = r_is_end;
        n_hit_clr = 1'b0;
        n_dec_sym = r_dec_sym;
        n_dec_len = r_dec_len;
        n_k       = r_k;
        n_ovld    = r_ovld && !i_out_ready;
        n_odata   = r_odata;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.mode)
                        MODE_ENCODE: begin
                            n_window = push_window;
                            n_fill   = r_fill + 3'd1;
                            if (r_fill == 3'(SYM_BYTES - 1)) begin
                                n_avail   = 3'(SYM_BYTES);
                                n_is_end  = 1'b0;
                                n_addr    = '0;
                                n_hit_clr = 1'b1;
                                n_state   = ST_SCAN;
                            end
                        end
                        MODE_END: begin
                            if (r_fill != 3'd0) begin
                                n_avail   = r_fill;
                                n_is_end  = 1'b1;
                                n_addr    = '0;
                                n_hit_clr = 1'b1;
                                n_state   = ST_SCAN;
                            end
                        end
                        MODE_DECODE: begin
                            if (dec_ok) begin
                                n_state = ST_DRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovld              = 1'b1;
                    n_odata.out_byte    = 8'(pick_code);
                    n_odata.last_of_run = !r_is_end || (left_fill == 3'd0);
                    n_fill              = left_fill;
                    case (pick_used)
                        3'd1:    n_window = r_window >> 8;
                        3'd2:    n_window = r_window >> 16;
                        3'd3:    n_window = r_window >> 24;
                        default: n_window = '0;
                    endcase
                    if (r_is_end && (left_fill != 3'd0)) begin
                        n_avail   = left_fill;
                        n_addr    = '0;
                        n_hit_clr = 1'b1;
                        n_state   = ST_SCAN;
                    end else begin
                        if (r_is_end) begin
                            n_window = '0;
                            n_fill   = 3'd0;
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DRD: begin
                n_dec_sym = ram_entry.sym;
                n_dec_len = dec_len;
                n_k       = 2'd0;
                n_state   = (dec_len == 3'd0) ? ST_IDLE : ST_DEMIT;
            end
            ST_DEMIT: begin
                if (out_free) begin
                    n_ovld              = 1'b1;
                    n_odata.out_byte    = r_dec_sym[{r_k, 3'b000} +: 8];
                    n_odata.last_of_run = ((3'(r_k) + 3'd1) == r_dec_len);
                    n_k                 = r_k + 2'd1;
                    if ((3'(r_k) + 3'd1) == r_dec_len) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_addr     <= '0;
            r_cmp_vld  <= 1'b0;
            r_window   <= '0;
            r_fill     <= 3'd0;
            r_avail    <= 3'd0;
            r_is_end   <= 1'b0;
            r_vld_bits <= '0;
            r_hit_vld  <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cmp_vld <= (r_state == ST_SCAN);
            r_window  <= n_window;
            r_fill    <= n_fill;
            r_avail   <= n_avail;
            r_is_end  <= n_is_end;
            r_ovld    <= n_ovld;
            if (in_acc && (i_in_data.mode == MODE_LOAD) && load_ok) begin
                r_vld_bits[i_in_data.entry_index[IDX_W-1:0]] <= 1'b1;
            end
            if (n_hit_clr) begin
                r_hit_vld <= '0;
            end else begin
                r_hit_vld <= r_hit_vld | hit;
            end
        end
    end

    // Payload registers: read tracking, best hits, decode data, output beat.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        r_ent_vld <= r_vld_bits[rd_addr];
        for (int j = 0; j < SYM_BYTES; j++) begin
            if (hit[j]) begin
                r_hit_idx[j] <= r_cmp_idx;
            end
        end
        r_dec_sym <= n_dec_sym;
        r_dec_len <= n_dec_len;
        r_k       <= n_k;
        r_odata   <= n_odata;
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

endmodule

FILE: hw/rtl/gdsc_ram.sv
// ----------------------------------------------------------------------------
// gdsc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/gdsc_match.sv
// ----------------------------------------------------------------------------
// gdsc_match: codebook entry compare unit
// Checks one entry against the window prefix of every allowed length.
// ----------------------------------------------------------------------------
module gdsc_match
    import gdsc_pkg::*;
(
    input  t_entry       i_entry,
    input  logic         i_entry_vld,
    input  logic [31:0]  i_window,
    input  logic [2:0]   i_avail,
    output logic [3:0]   o_hit
);

    // Bit L-1 is set when the entry holds exactly L bytes equal to the
    // first L window bytes, and L bytes are available.
    always_comb begin
        for (int l = 1; l <= SYM_BYTES; l++) begin
            o_hit[l-1] = i_entry_vld
                       && (i_entry.len == 3'(l))
                       && (i_entry.sym == (i_window & prefix_mask(3'(l))))
                       && (3'(l) <= i_avail);
        end
    end

endmodule

FILE: hw/rtl/gdsc_checker.sv
// ----------------------------------------------------------------------------
// gdsc_checker: port-level checks for the dictionary symbol coder
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module gdsc_checker
    import gdsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       o_in_ready,
    input  t_in_beat   i_in_data,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_out_beat  o_out_data
);

    // A stalled result beat stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // A codebook load never makes the block busy.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.mode == MODE_LOAD) |=> o_in_ready)
        else $error("block busy after a codebook load");

    // A new result beat only comes out of work in progress.
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result beat appeared while the block was idle");

endmodule

bind greedy_dictionary_symbol_coder_unit gdsc_checker u_gdsc_checker (.*);

FILE: verif/tb_greedy_dictionary_symbol_coder_unit.sv
// ----------------------------------------------------------------------------
// tb_greedy_dictionary_symbol_coder_unit: self-checking bench for the coder
// Loads codebook entries, encodes symbol streams, flushes them and decodes
// codes. A scoreboard class predicts every output beat, and plain tasks drive
// both valid/ready channels with random idling and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_greedy_dictionary_symbol_coder_unit;
    import gdsc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;

    // Predicts the output beats of the coder and checks the beats that leave it.
    class symbol_stream_checker;
        logic [2:0]  book_len [BOOK_ENTRIES];
        logic [31:0] book_sym [BOOK_ENTRIES];
        logic [31:0] window;
        int          fill;
        t_out_beat   awaited_beats[$];
        int          errors;

        function new();
            foreach (book_len[i]) begin
                book_len[i] = 3'd0;
                book_sym[i] = 32'd0;
            end
            window = 32'd0;
            fill   = 0;
            errors = 0;
        endfunction

        // Keeps the first n symbol bytes of a word.
        function logic [31:0] keep_bytes(int n);
            return (n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
        endfunction

        // Highest entry of exactly n bytes equal to key, or -1.
        function int find_entry(int n, logic [31:0] key);
            for (int i = BOOK_ENTRIES - 1; i >= 0; i--) begin
                if (book_len[i] == n && book_sym[i] == key)
                    return i;
            end
            return -1;
        endfunction

        // Longest match at the front of the window, using at most avail bytes.
        // Entry zero never counts as a hit, so it doubles as the miss code.
        function logic [7:0] code_front(int avail, output int used);
            int n;
            int hit;
            for (n = (avail > 4) ? 4 : avail; n >= 2; n--) begin
                hit = find_entry(n, window & keep_bytes(n));
                if (hit > 0) begin
                    used = n;
                    return hit[7:0];
                end
            end
            hit  = find_entry(1, window & keep_bytes(1));
            used = 1;
            return (hit > 0) ? hit[7:0] : 8'd0;
        endfunction

        function void drop_front(int n);
            window = (n >= 4) ? 32'd0 : (window >> (8 * n));
            fill   = (fill >= n) ? fill - n : 0;
        endfunction

        // Queues the beats of one item, flagging the final one.
        function void post_run(t_out_beat run[$]);
            if (run.size() == 0)
                return;
            run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[k])
                awaited_beats.push_back(run[k]);
        endfunction

        // Called for every input beat accepted by the block.
        function void accept_item(t_in_beat b);
            t_out_beat   run[$];
            logic [7:0]  code;
            logic [31:0] word;
            int          used;
            int          n;
            case (b.mode)
                MODE_LOAD: begin
                    n = (b.entry_length > 3'd4) ? 4 : b.entry_length;
                    if (b.entry_index < BOOK_ENTRIES) begin
                        book_len[b.entry_index] = n[2:0];
                        book_sym[b.entry_index] = b.entry_bytes & keep_bytes(n);
                    end
                end
                MODE_ENCODE: begin
                    window = (window & keep_bytes(fill)) | ({24'd0, b.value} << (8 * fill));
                    fill++;
                    if (fill == 4) begin
                        code = code_front(4, used);
                        drop_front(used);
                        awaited_beats.push_back('{out_byte: code, last_of_run: 1'b1});
                    end
                end
                MODE_END: begin
                    while (fill > 0 && run.size() < 4) begin
                        code = code_front(fill, used);
                        drop_front(used);
                        run.push_back('{out_byte: code, last_of_run: 1'b0});
                    end
                    window = 32'd0;
                    fill   = 0;
                    post_run(run);
                end
                default: begin
                    // Decode: an empty entry or a code past the book gives nothing.
                    if (b.value < BOOK_ENTRIES) begin
                        n    = (book_len[b.value] > 3'd4) ? 4 : book_len[b.value];
                        word = book_sym[b.value];
                        for (int k = 0; k < n; k++)
                            run.push_back('{out_byte: word[8 * k +: 8], last_of_run: 1'b0});
                        post_run(run);
                    end
                end
            endcase
        endfunction

        // Called for every output beat taken from the block.
        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (awaited_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output beat: byte %02h last %0b",
                             got.out_byte, got.last_of_run);
                return;
            end
            want = awaited_beats.pop_front();
            if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"output beat mismatch: expected byte %02h last %0b, ",
                              "got byte %02h last %0b"},
                             want.out_byte, want.last_of_run, got.out_byte, got.last_of_run);
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    symbol_stream_checker chk = new();

    // Idling odds in percent, and the long output hold-off request.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_len      = 0;
    int cycle_count   = 0;

    // Recently loaded entries, used to build streams that actually match.
    logic [7:0]  pool_idx  [8];
    logic [31:0] pool_word [8];
    int          pool_len  [8];
    int          pool_count = 0;

    greedy_dictionary_symbol_coder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL greedy_dictionary_symbol_coder_unit");
        $finish;
    end

    // Output side: take beats, stall at random, and honor hold-off requests.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                chk.check_beat(o_out_data);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offers one beat after random idle cycles and returns at its acceptance.
    task automatic send_item(t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        chk.accept_item(b);
    endtask

    // A beat of the given kind with every field filled at random.
    function automatic t_in_beat noise_beat(t_mode m);
        t_in_beat b;
        b.mode         = m;
        b.entry_index  = 8'($urandom_range(255));
        b.entry_length = 3'($urandom_range(7));
        b.entry_bytes  = $urandom;
        b.value        = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic void remember(logic [7:0] idx, int len, logic [31:0] word);
        int slot;
        if (len == 0)
            return;
        slot = (pool_count < 8) ? pool_count : $urandom_range(7);
        if (pool_count < 8)
            pool_count++;
        pool_idx[slot]  = idx;
        pool_word[slot] = word;
        pool_len[slot]  = (len > 4) ? 4 : len;
    endfunction

    task automatic send_load(logic [7:0] idx, logic [2:0] len, logic [31:0] word);
        t_in_beat b;
        b              = noise_beat(MODE_LOAD);
        b.entry_index  = idx;
        b.entry_length = len;
        b.entry_bytes  = word;
        remember(idx, int'(len), word);
        send_item(b);
    endtask

    task automatic send_encode(logic [7:0] sym);
        t_in_beat b;
        b       = noise_beat(MODE_ENCODE);
        b.value = sym;
        send_item(b);
    endtask

    task automatic send_end();
        send_item(noise_beat(MODE_END));
    endtask

    task automatic send_decode(logic [7:0] code);
        t_in_beat b;
        b       = noise_beat(MODE_DECODE);
        b.value = code;
        send_item(b);
    endtask

    // Symbols drawn mostly from a small alphabet so that entries repeat.
    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'h5A;
            2:       return 8'hA5;
            3:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Random traffic: mostly streams built from loaded entries, some noise.
    task automatic run_random_phase(int count, int idle, int stall);
        int          sent;
        int          r;
        int          s;
        int          n;
        logic [7:0]  idx;
        logic [31:0] word;
        send_idle_pct = idle;
        stall_pct     = stall;
        sent          = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 20) begin
                r   = $urandom_range(99);
                idx = (r < 15) ? 8'd0 : (r < 30) ? 8'd255 : 8'($urandom_range(255));
                r   = $urandom_range(99);
                if (r < 40 && pool_count > 0)
                    word = pool_word[$urandom_range(pool_count - 1)];
                else if (r < 80)
                    word = {pick_symbol(), pick_symbol(), pick_symbol(), pick_symbol()};
                else
                    word = $urandom;
                send_load(idx, 3'($urandom_range(7)), word);
                sent++;
            end else if (r < 70) begin
                if ($urandom_range(99) < 60 && pool_count > 0) begin
                    s = $urandom_range(pool_count - 1);
                    for (int k = 0; k < pool_len[s]; k++) begin
                        word = pool_word[s] >> (8 * k);
                        send_encode(word[7:0]);
                        sent++;
                    end
                end else begin
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        send_encode(pick_symbol());
                        sent++;
                    end
                end
            end else if (r < 80) begin
                send_end();
                sent++;
            end else begin
                if ($urandom_range(99) < 70 && pool_count > 0)
                    send_decode(pool_idx[$urandom_range(pool_count - 1)]);
                else
                    send_decode(8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty book and empty window: nothing comes out.
        send_decode(8'd0);
        send_end();

        // A small book with the edge cases: saturated length, entry zero,
        // duplicate single bytes, zero symbols and junk above the length.
        send_load(8'd255, 3'd4, 32'hFFFF_FFFF);
        send_load(8'd0,   3'd2, 32'h0000_4241);
        send_load(8'd1,   3'd7, 32'h4443_4241);
        send_load(8'd2,   3'd1, 32'hFFFF_FF41);
        send_load(8'd3,   3'd3, 32'h0000_0000);
        send_load(8'd4,   3'd1, 32'h0000_0041);
        send_load(8'd5,   3'd0, 32'h1234_5678);

        // Four-byte match, then a two-byte hit on entry zero that falls back
        // to a single byte, a miss, a three-byte zero match and a flush.
        send_encode(8'h41);
        send_encode(8'h42);
        send_encode(8'h43);
        send_encode(8'h44);
        send_encode(8'h41);
        send_encode(8'h42);
        send_encode(8'h00);
        send_encode(8'h00);
        send_encode(8'h00);
        send_encode(8'h00);
        send_end();

        // Three leftover bytes with no entries: the flush emits three misses.
        send_encode(8'hFE);
        send_encode(8'hFE);
        send_encode(8'hFE);
        send_end();

        send_decode(8'd5);
        send_decode(8'd1);

        // Long output hold-off while four-byte decodes keep arriving.
        hold_len = 600;
        hold_req = hold_req + 1;
        repeat (4) begin
            send_decode(8'd1);
            send_decode(8'd255);
        end

        run_random_phase(33, 0, 0);
        run_random_phase(33, 78, 0);
        run_random_phase(33, 0, 78);
        run_random_phase(33, 6, 6);

        i_in_valid    <= 1'b0;
        stall_pct     = 0;
        send_idle_pct = 0;
        while (chk.awaited_beats.size() != 0)
            @(posedge i_clk);
        repeat (BOOK_ENTRIES * 3 + 16) @(posedge i_clk);

        if (chk.errors == 0 && chk.awaited_beats.size() == 0) begin
            $display("PASS greedy_dictionary_symbol_coder_unit");
        end else begin
            $display("FAIL greedy_dictionary_symbol_coder_unit");
        end
        $finish;
    end

endmodule
